// File: rtl/ogm_pkg.sv
// ----------------------------------------------------------------------------
// ogm_pkg
// Shared types, codes and constants of the occupancy grid marker.
// ----------------------------------------------------------------------------
package ogm_pkg;

  localparam int GRID_WIDTH_DEF   = 128;
  localparam int GRID_HEIGHT_DEF  = 128;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam int IN_DATA_W  = 184;
  localparam int OUT_DATA_W = 24;
  localparam int CFG_W      = 24;
  localparam int CORD_W     = 36;
  localparam int ACC_W      = 66;
  localparam int PROD_W     = 44;

  typedef enum logic [1:0] {
    KIND_POSE = 2'd0,
    KIND_BEAM = 2'd1,
    KIND_READ = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_CELLS_PER_METRE = 2'd0,
    REG_START_ANGLE     = 2'd1,
    REG_ANGLE_STEP      = 2'd2,
    REG_MAX_RANGE       = 2'd3
  } reg_idx_t;

  localparam logic [1:0] CELL_UNKNOWN  = 2'd0;
  localparam logic [1:0] CELL_CENTRE   = 2'd1;
  localparam logic [1:0] CELL_OCCUPIED = 2'd2;

  localparam logic signed [7:0] VAL_UNKNOWN  = -8'sd1;
  localparam logic signed [7:0] VAL_CENTRE   = 8'sd50;
  localparam logic signed [7:0] VAL_OCCUPIED = 8'sd100;

  localparam logic [23:0] CPM_RESET   = 24'd655360;
  localparam logic [15:0] START_RESET = 16'h8000;
  localparam logic [15:0] STEP_RESET  = 16'd182;
  localparam logic [23:0] MAXR_RESET  = 24'd786432;

  localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 36'sd652032874;
  localparam logic signed [CORD_W-1:0] QUAT_ONE    = 36'sd268435456;

  typedef struct packed {
    logic                     go;
    logic                     clr;
    logic                     sh16;
    logic signed [17:0]       a;
    logic signed [25:0]       b;
  } mac_op_t;

  typedef struct packed {
    logic                     go;
    logic                     vec;
    logic signed [CORD_W-1:0] x;
    logic signed [CORD_W-1:0] y;
    logic [15:0]              ang;
  } cordic_cmd_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] t;
    case (i)
      5'd0:    t = 32'h20000000;
      5'd1:    t = 32'h12E4051E;
      5'd2:    t = 32'h09FB385B;
      5'd3:    t = 32'h051111D4;
      5'd4:    t = 32'h028B0D43;
      5'd5:    t = 32'h0145D7E1;
      5'd6:    t = 32'h00A2F61E;
      5'd7:    t = 32'h00517C55;
      5'd8:    t = 32'h0028BE53;
      5'd9:    t = 32'h00145F2F;
      5'd10:   t = 32'h000A2F98;
      5'd11:   t = 32'h000517CC;
      5'd12:   t = 32'h00028BE6;
      5'd13:   t = 32'h000145F3;
      5'd14:   t = 32'h0000A2FA;
      5'd15:   t = 32'h0000517D;
      5'd16:   t = 32'h000028BE;
      5'd17:   t = 32'h0000145F;
      5'd18:   t = 32'h00000A30;
      5'd19:   t = 32'h00000518;
      5'd20:   t = 32'h0000028C;
      5'd21:   t = 32'h00000146;
      5'd22:   t = 32'h000000A3;
      5'd23:   t = 32'h00000051;
      default: t = 32'h00000000;
    endcase
    return t;
  endfunction

endpackage

// File: rtl/ogm_ram.sv
// ----------------------------------------------------------------------------
// ogm_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ogm_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/ogm_mac.sv
// ----------------------------------------------------------------------------
// ogm_mac
// Shared multiply-accumulate: registered 18x26 product, then accumulate.
// ----------------------------------------------------------------------------
module ogm_mac
  import ogm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  mac_op_t                 op,
  output logic signed [ACC_W-1:0] acc
);

  logic signed [PROD_W-1:0] prod;
  logic                     vld;
  logic                     clr;
  logic                     sh16;
  logic signed [ACC_W-1:0]  term;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= op.go;
    end
    prod <= op.a * op.b;
    clr  <= op.clr;
    sh16 <= op.sh16;
  end

  always_comb begin
    term = ACC_W'(prod);
    if (sh16) begin
      term = term <<< 16;
    end
  end

  always_ff @(posedge clk) begin
    if (vld) begin
      acc <= (clr ? '0 : acc) + term;
    end
  end

endmodule

// File: rtl/ogm_cordic.sv
// ----------------------------------------------------------------------------
// ogm_cordic
// Iterative CORDIC, one micro-rotation per cycle, vectoring or rotation mode.
// ----------------------------------------------------------------------------
module ogm_cordic
  import ogm_pkg::*;
#(
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cordic_cmd_t              cmd,
  output logic                     busy,
  output logic signed [CORD_W-1:0] x,
  output logic signed [CORD_W-1:0] y,
  output logic [31:0]              z
);

  logic                     vec;
  logic [4:0]               i;
  logic signed [CORD_W-1:0] xs;
  logic signed [CORD_W-1:0] ys;
  logic [31:0]              t;
  logic [31:0]              z0;
  logic                     up;

  assign xs = x >>> i;
  assign ys = y >>> i;
  assign t  = atan_turn(i);
  assign z0 = {cmd.ang, 16'h0000};
  assign up = vec ? (y > 0) : (z < 32'h80000000);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      i    <= '0;
    end else if (cmd.go) begin
      busy <= 1'b1;
      i    <= '0;
      vec  <= cmd.vec;
      if (cmd.vec) begin
        if (cmd.x < 0) begin
          x <= -cmd.x;
          y <= -cmd.y;
          z <= 32'h80000000;
        end else begin
          x <= cmd.x;
          y <= cmd.y;
          z <= '0;
        end
      end else begin
        y <= '0;
        if (z0[31:30] == 2'd1 || z0[31:30] == 2'd2) begin
          x <= -CORDIC_GAIN;
          z <= z0 - 32'h80000000;
        end else begin
          x <= CORDIC_GAIN;
          z <= z0;
        end
      end
    end else if (busy) begin
      if (vec && y == 0) begin
        // no move on an axis hit
      end else if (up == vec) begin
        x <= x + ys;
        y <= y - xs;
        z <= vec ? z + t : z + t;
      end else begin
        x <= x - ys;
        y <= y + xs;
        z <= z - t;
      end
      i <= i + 5'd1;
      if (i == 5'(STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/lidar_occupancy_grid_marker.sv
// Throughput: one item at a time; a new item is accepted only in the idle state,
// once the previous result has been put on the output, and an output stall
// holds it back. The CORDIC and MAC are shared by the pose and beam paths.
// Reset: synchronous; a clearing pass then writes every grid cell to unknown
// with the centre mark, and no input is taken meanwhile.
// ----------------------------------------------------------------------------
// lidar_occupancy_grid_marker
// Occupancy grid updated from robot pose and lidar beams, with cell reads.
// ----------------------------------------------------------------------------
module lidar_occupancy_grid_marker
  import ogm_pkg::*;
#(
  parameter int GRID_WIDTH   = GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT  = GRID_HEIGHT_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // pos_x, pos_y, quat_w, quat_x, quat_y, quat_z, beam_index, beam_range,
  // range_infinite, read_index, zero pad
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // kind
  input  logic [1:0]            s_tuser,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // cell_value, hit_marked, hit_index, zero pad
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  localparam int CELLS  = GRID_WIDTH * GRID_HEIGHT;
  localparam int AW     = $clog2(CELLS);
  localparam int CW     = $clog2(GRID_WIDTH > GRID_HEIGHT ? GRID_WIDTH : GRID_HEIGHT);
  localparam int CENTRE = (GRID_HEIGHT / 2) * GRID_WIDTH + GRID_WIDTH / 2;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE,
    ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6, ST_PCOR,
    ST_B0, ST_B1, ST_B2, ST_BCOR,
    ST_C0, ST_C1, ST_C2, ST_C3, ST_C4, ST_C5, ST_C6, ST_C7,
    ST_MARK, ST_R0, ST_R1, ST_OUT
  } state_t;

  state_t state, state_next;

  logic [23:0] cpm;
  logic [15:0] start_ang;
  logic [15:0] step;
  logic [23:0] maxr;

  logic signed [31:0] robot_x, robot_y;
  logic [15:0]        heading;

  logic [IN_DATA_W-1:0] item;
  logic signed [15:0]   qw, qx, qy, qz;
  logic [11:0]          bidx;
  logic [23:0]          brange;
  logic                 binf;
  logic [13:0]          ridx;

  logic [AW-1:0]          clr_addr;
  logic [24:0]            rsel;
  logic signed [CORD_W-1:0] num;
  logic                   axis;
  logic signed [33:0]     pt;
  logic [CW-1:0]          mx, my;
  logic                   inx, iny;
  logic                   rd_out;

  logic signed [7:0] res_cell;
  logic              res_hit;
  logic [13:0]       res_idx;

  mac_op_t                 mop;
  logic signed [ACC_W-1:0] acc;
  cordic_cmd_t             ccmd;
  logic                    cbusy;
  logic signed [CORD_W-1:0] cx, cy;
  logic [31:0]             cz;

  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr;
  logic [1:0]          ram_wdata;
  logic [1:0]          ram_rdata;

  logic signed [33:0]       trig;
  logic signed [31:0]       pos;
  logic signed [ACC_W-1:0]  psum;
  logic signed [ACC_W-1:0]  vsum;
  logic [ACC_W-1:0]         vmag;
  logic [ACC_W-33:0]        q;
  logic                     v_in;
  logic [CW-1:0]            v_coord;
  logic [AW-1:0]            hidx;
  logic                     out_free;

  assign qw     = item[79:64];
  assign qx     = item[95:80];
  assign qy     = item[111:96];
  assign qz     = item[127:112];
  assign bidx   = item[139:128];
  assign brange = item[163:140];
  assign binf   = item[164];
  assign ridx   = item[178:165];

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  assign trig = axis ? cy[33:0] : cx[33:0];
  assign pos  = axis ? robot_y : robot_x;
  assign psum = acc + (ACC_W'(pos) <<< 30);
  assign vsum = acc + (ACC_W'(axis ? GRID_HEIGHT : GRID_WIDTH) << 31);
  assign vmag = vsum[ACC_W-1] ? ACC_W'(-vsum) : ACC_W'(vsum);
  assign q    = vmag[ACC_W-1:32];
  assign v_in = vsum[ACC_W-1] ? (q == '0)
              : (q < (ACC_W-32)'(axis ? GRID_HEIGHT : GRID_WIDTH));
  assign v_coord = vsum[ACC_W-1] ? '0 : CW'(q);
  assign hidx = AW'(int'(my) * GRID_WIDTH + int'(mx));

  ogm_mac u_mac (
    .clk (clk),
    .rst (rst),
    .op  (mop),
    .acc (acc)
  );

  ogm_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk  (clk),
    .rst  (rst),
    .cmd  (ccmd),
    .busy (cbusy),
    .x    (cx),
    .y    (cy),
    .z    (cz)
  );

  ogm_ram #(.WIDTH(2), .DEPTH(CELLS)) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (AW'(ridx)),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cpm       <= CPM_RESET;
      start_ang <= START_RESET;
      step      <= STEP_RESET;
      maxr      <= MAXR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CELLS_PER_METRE: cpm       <= cfg_data;
        REG_START_ANGLE:     start_ang <= cfg_data[15:0];
        REG_ANGLE_STEP:      step      <= cfg_data[15:0];
        REG_MAX_RANGE:       maxr      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      m_tvalid <= 1'b0;
      robot_x  <= '0;
      robot_y  <= '0;
      heading  <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (state == ST_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end
      if (state == ST_PCOR && !cbusy) begin
        robot_x <= item[31:0];
        robot_y <= item[63:32];
        heading <= 16'((cz + 32'h8000) >> 16);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item <= s_tdata;
    end
    if (state == ST_OUT && out_free) begin
      m_tdata <= {1'b0, res_idx, res_hit, res_cell};
    end
    case (state)
      ST_IDLE: begin
        res_cell <= '0;
        res_hit  <= 1'b0;
        res_idx  <= '0;
        axis     <= 1'b0;
        rd_out   <= 1'b0;
      end
      ST_P3:   num  <= CORD_W'(acc) <<< 1;
      ST_B0:   rsel <= (binf || brange == '0) ? {1'b0, maxr} : {1'b0, brange};
      ST_C3:   pt   <= psum[63:30];
      ST_C7: begin
        if (axis) begin
          my  <= v_coord;
          iny <= v_in;
        end else begin
          mx  <= v_coord;
          inx <= v_in;
        end
        axis <= 1'b1;
      end
      ST_MARK: begin
        res_hit <= inx && iny;
        res_idx <= (inx && iny) ? 14'(hidx) : '0;
      end
      ST_R0:   rd_out <= ({{(32-14){1'b0}}, ridx} < 32'(CELLS));
      ST_R1: begin
        if (!rd_out) begin
          res_cell <= VAL_UNKNOWN;
        end else begin
          case (ram_rdata)
            CELL_OCCUPIED: res_cell <= VAL_OCCUPIED;
            CELL_CENTRE:   res_cell <= VAL_CENTRE;
            default:       res_cell <= VAL_UNKNOWN;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    mop        = '0;
    ccmd       = '0;
    ram_we     = 1'b0;
    ram_waddr  = clr_addr;
    ram_wdata  = CELL_UNKNOWN;
    ram_re     = 1'b0;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = (clr_addr == AW'(CENTRE)) ? CELL_CENTRE : CELL_UNKNOWN;
        if (clr_addr == AW'(CELLS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          case (s_tuser)
            KIND_POSE: state_next = ST_P0;
            KIND_BEAM: state_next = ST_B0;
            KIND_READ: state_next = ST_R0;
            default:   state_next = ST_OUT;
          endcase
        end
      end
      ST_P0: begin
        mop = '{go: 1'b1, clr: 1'b1, sh16: 1'b0, a: 18'(qw), b: 26'(qz)};
        state_next = ST_P1;
      end
      ST_P1: begin
        mop = '{go: 1'b1, clr: 1'b0, sh16: 1'b0, a: 18'(qx), b: 26'(qy)};
        state_next = ST_P2;
      end
      ST_P2: state_next = ST_P3;
      ST_P3: begin
        mop = '{go: 1'b1, clr: 1'b1, sh16: 1'b0, a: 18'(qy), b: 26'(qy)};
        state_next = ST_P4;
      end
      ST_P4: begin
        mop = '{go: 1'b1, clr: 1'b0, sh16: 1'b0, a: 18'(qz), b: 26'(qz)};
        state_next = ST_P5;
      end
      ST_P5: state_next = ST_P6;
      ST_P6: state_next = ST_PCOR;
      ST_PCOR: begin
        if (!cbusy) begin
          state_next = ST_OUT;
        end
      end
      ST_B0: begin
        mop = '{go: 1'b1, clr: 1'b1, sh16: 1'b0,
                a: 18'({6'b0, bidx}), b: 26'({10'b0, step})};
        state_next = ST_B1;
      end
      ST_B1: state_next = ST_B2;
      ST_B2: begin
        ccmd.go  = 1'b1;
        ccmd.ang = heading + start_ang + acc[15:0];
        state_next = ST_BCOR;
      end
      ST_BCOR: begin
        if (!cbusy) begin
          state_next = ST_C0;
        end
      end
      ST_C0: begin
        mop = '{go: 1'b1, clr: 1'b1, sh16: 1'b0,
                a: 18'({2'b0, trig[15:0]}), b: 26'(rsel)};
        state_next = ST_C1;
      end
      ST_C1: begin
        mop = '{go: 1'b1, clr: 1'b0, sh16: 1'b1, a: trig[33:16], b: 26'(rsel)};
        state_next = ST_C2;
      end
      ST_C2: state_next = ST_C3;
      ST_C3: state_next = ST_C4;
      ST_C4: begin
        mop = '{go: 1'b1, clr: 1'b1, sh16: 1'b0,
                a: 18'({2'b0, pt[15:0]}), b: 26'({2'b0, cpm})};
        state_next = ST_C5;
      end
      ST_C5: begin
        mop = '{go: 1'b1, clr: 1'b0, sh16: 1'b1, a: pt[33:16], b: 26'({2'b0, cpm})};
        state_next = ST_C6;
      end
      ST_C6: state_next = ST_C7;
      ST_C7: state_next = axis ? ST_MARK : ST_C0;
      ST_MARK: begin
        ram_we     = inx && iny;
        ram_waddr  = hidx;
        ram_wdata  = CELL_OCCUPIED;
        state_next = ST_OUT;
      end
      ST_R0: begin
        ram_re     = 1'b1;
        state_next = ST_R1;
      end
      ST_R1: state_next = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    if (state == ST_P6) begin
      ccmd.go  = 1'b1;
      ccmd.vec = 1'b1;
      ccmd.x   = QUAT_ONE - (CORD_W'(acc) <<< 1);
      ccmd.y   = num;
    end
  end

endmodule

// File: rtl/ogm_checker.sv
// ----------------------------------------------------------------------------
// ogm_checker
// Port-level checks of the occupancy grid marker, bound to the top level.
// ----------------------------------------------------------------------------
module ogm_checker
  import ogm_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic                  m_tvalid,
  input logic                  m_tready
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while busy");

  a_idx_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[8] |-> m_tdata[22:9] == 14'd0)
    else $error("hit index without a hit");

  a_cell_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7:0] == 8'd0 || m_tdata[7:0] == 8'hFF ||
                  m_tdata[7:0] == 8'd50 || m_tdata[7:0] == 8'd100))
    else $error("bad cell value");

  a_cell_no_hit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[7:0] != 8'd0 |-> !m_tdata[8])
    else $error("read answer with a hit");

endmodule

bind lidar_occupancy_grid_marker ogm_checker u_ogm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tdata  (m_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);

// File: verif/tb_lidar_occupancy_grid_marker.sv
// ----------------------------------------------------------------------------
// tb_lidar_occupancy_grid_marker
// Streams pose, beam, read and unused-kind items through the grid marker with random
// stalls on both sides. A local model of the grid, pose and registers
// predicts each result, and the outputs are checked field by field.
// ----------------------------------------------------------------------------
module tb_lidar_occupancy_grid_marker;
  import ogm_pkg::*;

  localparam int GW = 128;
  localparam int GH = 128;
  localparam int NCELL = GW * GH;
  localparam int STEPS = 16;
  localparam int LIMIT = 3000000;

  typedef struct {
    kind_t                kind;
    logic [IN_DATA_W-1:0] data;
  } item_t;

  typedef struct {
    logic [7:0]  cell_val;
    logic        hit;
    logic [13:0] idx;
  } answer_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [1:0]            s_tuser;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic                  cfg_we;
  logic [1:0]            cfg_index;
  logic [CFG_W-1:0]      cfg_data;

  item_t   pending[$];
  answer_t answers[$];
  int      hits[$];
  int      errors;
  int      cycles;
  bit      calm;

  logic [1:0]  occ[NCELL];
  longint      rob_x, rob_y;
  logic [15:0] rob_yaw;
  logic [23:0] cpm, maxr;
  logic [15:0] start_ang, step_ang;

  lidar_occupancy_grid_marker dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [31:0] yaw_turns(longint y, longint x);
    logic [31:0] acc;
    longint xs, ys;
    acc = 32'd0;
    if (x < 0) begin
      x = -x;
      y = -y;
      acc = 32'h80000000;
    end
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; acc += atan_turn(5'(i));
      end else if (y < 0) begin
        x -= ys; y += xs; acc -= atan_turn(5'(i));
      end
    end
    return acc;
  endfunction

  function automatic void sincos(input logic [15:0] ang, output longint c, output longint s);
    logic [31:0] z;
    longint x, y, xs, ys;
    z = {ang, 16'd0};
    x = longint'(CORDIC_GAIN);
    y = 0;
    if (z[31:30] == 2'd1 || z[31:30] == 2'd2) begin
      x = -x;
      z -= 32'h80000000;
    end
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z < 32'h80000000) begin
        x -= ys; y += xs; z -= atan_turn(5'(i));
      end else begin
        x += ys; y -= xs; z += atan_turn(5'(i));
      end
    end
    c = x;
    s = y;
  endfunction

  function automatic longint cell_coord(longint pos, longint r, longint trig, longint size);
    longint pt, v;
    pt = (pos * 64'sd1073741824 + r * trig) >>> 30;
    v = pt * longint'(cpm) + size * 64'sd2147483648;
    return v >= 0 ? (v >>> 32) : -((-v) >>> 32);
  endfunction

  function automatic answer_t grid_update(item_t it);
    answer_t a;
    longint w, qx, qy, qz, num, den, c, s, mx, my;
    logic [31:0] turns, r;
    logic [15:0] ang;
    int idx;
    a = '{8'd0, 1'b0, 14'd0};
    case (it.kind)
      KIND_POSE: begin
        w  = longint'($signed(it.data[79:64]));
        qx = longint'($signed(it.data[95:80]));
        qy = longint'($signed(it.data[111:96]));
        qz = longint'($signed(it.data[127:112]));
        num = 2 * (w * qz + qx * qy);
        den = 64'sd268435456 - 2 * (qy * qy + qz * qz);
        turns = yaw_turns(num, den);
        rob_x = longint'($signed(it.data[31:0]));
        rob_y = longint'($signed(it.data[63:32]));
        rob_yaw = 16'((turns + 32'h8000) >> 16);
      end
      KIND_BEAM: begin
        r = {8'd0, it.data[163:140]};
        if (it.data[164] || r == 0) r = {8'd0, maxr};
        ang = 16'(32'(rob_yaw) + 32'(start_ang) + 32'(it.data[139:128]) * 32'(step_ang));
        sincos(ang, c, s);
        mx = cell_coord(rob_x, longint'(r), c, GW);
        my = cell_coord(rob_y, longint'(r), s, GH);
        if (mx >= 0 && mx < GW && my >= 0 && my < GH) begin
          idx = int'(my) * GW + int'(mx);
          occ[idx] = CELL_OCCUPIED;
          a.hit = 1'b1;
          a.idx = 14'(idx);
          hits.push_back(idx);
        end
      end
      KIND_READ: begin
        idx = int'(it.data[178:165]);
        a.cell_val = occ[idx] == CELL_OCCUPIED ? VAL_OCCUPIED :
                     occ[idx] == CELL_CENTRE ? VAL_CENTRE : VAL_UNKNOWN;
      end
      default: ;
    endcase
    return a;
  endfunction

  function automatic item_t mk(kind_t k, logic [31:0] px, logic [31:0] py,
                               logic [15:0] qw, logic [15:0] qx, logic [15:0] qy,
                               logic [15:0] qz, logic [11:0] bi, logic [23:0] br,
                               logic inf, logic [13:0] ri);
    item_t it;
    it.kind = k;
    it.data = {5'd0, ri, inf, br, bi, qz, qy, qx, qw, py, px};
    return it;
  endfunction

  function automatic logic [15:0] rand_quat();
    return 16'($urandom_range(0, 32768) - 16384);
  endfunction

  function automatic logic [31:0] rand_pos();
    if ($urandom_range(0, 9) == 0) return $urandom();
    return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
  endfunction

  task automatic add_random(int n);
    int sel;
    logic [23:0] br;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      br = $urandom_range(0, 3) == 0 ? 24'($urandom()) : 24'($urandom_range(0, 7 << 16));
      if (sel < 30)
        pending.push_back(mk(KIND_POSE, rand_pos(), rand_pos(), rand_quat(), rand_quat(),
                             rand_quat(), rand_quat(), 12'($urandom()), 24'($urandom()),
                             1'($urandom()), 14'($urandom())));
      else if (sel < 75)
        pending.push_back(mk(KIND_BEAM, $urandom(), $urandom(), 16'($urandom()),
                             16'($urandom()), 16'($urandom()), 16'($urandom()),
                             12'($urandom()), br, $urandom_range(0, 7) == 0,
                             14'($urandom())));
      else if (sel < 97)
        pending.push_back(mk(KIND_READ, $urandom(), $urandom(), 16'($urandom()),
                             16'($urandom()), 16'($urandom()), 16'($urandom()),
                             12'($urandom()), 24'($urandom()), 1'($urandom()),
                             (hits.size() > 0 && $urandom_range(0, 1)) ?
                               14'(hits[$urandom_range(0, hits.size() - 1)]) :
                               14'($urandom())));
      else
        pending.push_back(mk(KIND_NONE, $urandom(), $urandom(), 16'($urandom()),
                             16'($urandom()), 16'($urandom()), 16'($urandom()),
                             12'($urandom()), 24'($urandom()), 1'($urandom()),
                             14'($urandom())));
    end
  endtask

  task automatic write_reg(reg_idx_t r, logic [CFG_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    @(posedge clk);
    case (r)
      REG_CELLS_PER_METRE: cpm = v;
      REG_START_ANGLE:     start_ang = v[15:0];
      REG_ANGLE_STEP:      step_ang = v[15:0];
      default:             maxr = v;
    endcase
  endtask

  task automatic settle();
    while (pending.size() > 0 || s_tvalid || answers.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    item_t it;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        it.kind = kind_t'(s_tuser);
        it.data = s_tdata;
        answers.push_back(grid_update(it));
      end
      if (!s_tvalid || s_tready) begin
        if (pending.size() > 0 && (calm || $urandom_range(0, 99) >= 33)) begin
          it = pending.pop_front();
          s_tdata <= it.data;
          s_tuser <= it.kind;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    answer_t a;
    m_tready <= calm || $urandom_range(0, 99) >= 33;
    if (!rst && m_tvalid && m_tready) begin
      if (answers.size() == 0) begin
        report("unexpected transfer", 32'(m_tdata), 32'd0);
      end else begin
        a = answers.pop_front();
        if (m_tdata[7:0] !== a.cell_val)
          report("cell_value", 32'(m_tdata[7:0]), 32'(a.cell_val));
        if (m_tdata[8] !== a.hit) report("hit_marked", 32'(m_tdata[8]), 32'(a.hit));
        if (m_tdata[22:9] !== a.idx) report("hit_index", 32'(m_tdata[22:9]), 32'(a.idx));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_CELLS_PER_METRE;
    cfg_data = '0;
    errors = 0;
    cycles = 0;
    calm = 1'b0;
    for (int i = 0; i < NCELL; i++) occ[i] = CELL_UNKNOWN;
    occ[(GH / 2) * GW + GW / 2] = CELL_CENTRE;
    rob_x = 0;
    rob_y = 0;
    rob_yaw = 16'd0;
    cpm = CPM_RESET;
    start_ang = START_RESET;
    step_ang = STEP_RESET;
    maxr = MAXR_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: reset settings, extremes, degenerate quaternion, unused kind
    pending.push_back(mk(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 14'((GH / 2) * GW + GW / 2)));
    pending.push_back(mk(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 14'd0));
    pending.push_back(mk(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 14'h3FFF));
    pending.push_back(mk(KIND_BEAM, 0, 0, 0, 0, 0, 0, 12'd0, 24'd0, 1'b0, 0));
    pending.push_back(mk(KIND_BEAM, 0, 0, 0, 0, 0, 0, 12'hFFF, 24'd65536, 1'b1, 0));
    pending.push_back(mk(KIND_BEAM, 0, 0, 0, 0, 0, 0, 12'd500, 24'hFFFFFF, 1'b0, 0));
    pending.push_back(mk(KIND_BEAM, 0, 0, 0, 0, 0, 0, 12'd1000, 24'd200000, 1'b0, 0));
    pending.push_back(mk(KIND_POSE, 32'h7FFFFFFF, 32'h80000000, 16'h4000, 0, 0, 0, 0, 0, 0, 0));
    pending.push_back(mk(KIND_BEAM, 0, 0, 0, 0, 0, 0, 12'd0, 24'd1, 1'b0, 0));
    pending.push_back(mk(KIND_POSE, 0, 0, 16'd0, 16'd0, 16'd8192, 16'd8192, 0, 0, 0, 0));
    pending.push_back(mk(KIND_BEAM, 0, 0, 0, 0, 0, 0, 12'd700, 24'd300000, 1'b0, 0));
    pending.push_back(mk(KIND_POSE, 32'h00010000, 32'hFFFF0000, 16'hC000, 16'h4000,
                         16'hC000, 16'h4000, 0, 0, 0, 0));
    pending.push_back(mk(KIND_BEAM, 0, 0, 0, 0, 0, 0, 12'd1500, 24'd150000, 1'b0, 0));
    pending.push_back(mk(KIND_POSE, 0, 0, 16'd11585, 0, 0, 16'd11585, 0, 0, 0, 0));
    pending.push_back(mk(KIND_BEAM, 0, 0, 0, 0, 0, 0, 12'd0, 24'd100000, 1'b0, 0));
    pending.push_back(mk(KIND_NONE, '1, '1, '1, '1, '1, '1, '1, '1, 1'b1, '1));
    pending.push_back(mk(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 14'((GH / 2) * GW + GW / 2)));
    add_random(60);
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_CELLS_PER_METRE, 24'd1);
          write_reg(REG_START_ANGLE, 24'h007FFF);
          write_reg(REG_ANGLE_STEP, 24'h00FFFF);
          write_reg(REG_MAX_RANGE, 24'd0);
        end
        1: begin
          write_reg(REG_CELLS_PER_METRE, 24'hFFFFFF);
          write_reg(REG_START_ANGLE, 24'd0);
          write_reg(REG_ANGLE_STEP, 24'd0);
          write_reg(REG_MAX_RANGE, 24'hFFFFFF);
        end
        2: begin
          calm = 1'b1;
          write_reg(REG_CELLS_PER_METRE, CPM_RESET);
          write_reg(REG_START_ANGLE, START_RESET);
          write_reg(REG_ANGLE_STEP, STEP_RESET);
          write_reg(REG_MAX_RANGE, MAXR_RESET);
        end
        default: begin
          write_reg(REG_CELLS_PER_METRE, 24'($urandom_range(1 << 16, 40 << 16)));
          write_reg(REG_START_ANGLE, 24'($urandom()));
          write_reg(REG_ANGLE_STEP, 24'($urandom()));
          write_reg(REG_MAX_RANGE, 24'($urandom()));
        end
      endcase
      cfg_we <= 1'b0;
      add_random(115);
      settle();
      calm = 1'b0;
    end

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
